@@ hdl/double_ended_queue_macros.svh @@
// Assertion macros for the file that checks its own logic.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hdl/dq_pkg.sv @@
package dq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int ELEM_W        = 8;
  localparam int COUNT_W       = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ELEM_W-1:0] data;
  } cell_ctrl_t;

endpackage

@@ hdl/dq_if.sv @@
interface dq_in_if;
  import dq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ELEM_W-1:0] data_in;

  modport source (output valid, cmd, data_in, input ready);
  modport sink   (input valid, cmd, data_in, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic               valid;
  logic               ready;
  logic [ELEM_W-1:0]  data_out;
  logic [1:0]         status;
  logic [ELEM_W-1:0]  front_data;
  logic [ELEM_W-1:0]  rear_data;
  logic               is_empty;
  logic [COUNT_W-1:0] item_count;

  modport source (output valid, data_out, status, front_data, rear_data, is_empty,
                  item_count, input ready);
  modport sink   (input valid, data_out, status, front_data, rear_data, is_empty,
                  item_count, output ready);
endinterface

@@ hdl/dq_cell.sv @@
module dq_cell import dq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [ELEM_W-1:0] left_data,
  input  logic              left_valid,
  input  logic [ELEM_W-1:0] right_data,
  input  logic              right_valid,
  output logic [ELEM_W-1:0] data_o,
  output logic              valid_o,
  output logic [ELEM_W-1:0] rear_o
);

  logic [ELEM_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      OP_PUSH_FRONT: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      OP_PUSH_REAR: begin
        if (!valid_r && left_valid) begin
          data_nxt  = ctrl.data;
          valid_nxt = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      OP_POP_REAR: begin
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;
  assign rear_o  = (valid_r && !right_valid) ? data_r : '0;

endmodule

@@ hdl/double_ended_queue.sv @@
// Bounded double-ended queue of 8-bit elements, held in a row of DEPTH cells.
// The input channel in_chan carries one command per item: push front, push
// rear, pop front or pop rear, with the element to push. The output channel
// out_chan returns one result item per command: the popped element, a status
// (ok, pop on empty, push on full dropped), the front and rear elements after
// the command, an empty flag and the element count.
// The front element always sits in the first cell; a front push or pop shifts
// every cell by one place toward its neighbor in the same cycle, and a rear
// push or pop touches only the cell at the rear boundary.
// The result is registered: the cells and pend_r update when the command is
// accepted, and the result register then loads from the cells.
// One command is in flight at a time, so no new item is taken while one is
// pending; the result register waits for out_chan.ready without losing data,
// and in_chan.ready stays low while a result is held and not taken.
// Reset (rst_n low at a clock edge) empties the queue at once and drops any
// pending result.
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  dq_in_if.sink    in_chan,
  dq_out_if.source out_chan
);

  `include "double_ended_queue_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ELEM_W-1:0] cell_data [DEPTH];
  logic [ELEM_W-1:0] cell_rear [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  cell_ctrl_t        ctrl;

  logic [ELEM_W-1:0] rear_sel;
  logic              accept, is_push, full, empty, cmd_ok;
  logic              pend_r, out_valid_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ELEM_W-1:0] popped_r, popped_nxt;
  status_t           status_r, status_nxt;
  logic [ELEM_W-1:0] out_data_r, out_front_r, out_rear_r;
  logic [1:0]        out_status_r;
  logic              out_empty_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ELEM_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;
      if (gi == 0) begin : g_first
        assign l_data  = in_chan.data_in;
        assign l_valid = 1'b1;
      end else begin : g_mid_l
        assign l_data  = cell_data[gi-1];
        assign l_valid = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_data  = cell_data[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      dq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data_o      (cell_data[gi]),
        .valid_o     (cell_valid[gi]),
        .rear_o      (cell_rear[gi])
      );
    end
  endgenerate

  always_comb begin
    rear_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_sel = rear_sel | cell_rear[i];
    end
  end

  assign full    = cell_valid[DEPTH-1];
  assign empty   = !cell_valid[0];
  assign in_chan.ready = !pend_r && (!out_valid_r || out_chan.ready);
  assign accept  = in_chan.valid && in_chan.ready;
  assign is_push = !in_chan.cmd[1];
  assign cmd_ok  = is_push ? !full : !empty;

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.data  = in_chan.data_in;
    popped_nxt = '0;
    status_nxt = ST_OK;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (!cmd_ok) begin
        status_nxt = is_push ? ST_FULL : ST_EMPTY;
      end else begin
        unique case (cmd_t'(in_chan.cmd))
          CMD_PUSH_FRONT: begin
            ctrl.op = OP_PUSH_FRONT;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          CMD_PUSH_REAR: begin
            ctrl.op = OP_PUSH_REAR;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          CMD_POP_FRONT: begin
            ctrl.op    = OP_POP_FRONT;
            popped_nxt = cell_data[0];
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
          CMD_POP_REAR: begin
            ctrl.op    = OP_POP_REAR;
            popped_nxt = rear_sel;
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
    if (pend_r) begin
      out_data_r   <= popped_r;
      out_status_r <= status_r;
      out_front_r  <= empty ? '0 : cell_data[0];
      out_rear_r   <= rear_sel;
      out_empty_r  <= empty;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      pend_r <= accept;
      cnt_r  <= cnt_nxt;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.data_out   = out_data_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.front_data = out_front_r;
  assign out_chan.rear_data  = out_rear_r;
  assign out_chan.is_empty   = out_empty_r;
  assign out_chan.item_count = out_count_r;

  `DQ_ASSERT(a_count_matches_cells, clk, rst_n, cnt_r == CNT_W'($countones(cell_valid)), "count disagrees with the occupied cells")
  `DQ_ASSERT_NEVER(a_cells_packed, clk, rst_n, (cell_valid & (cell_valid + DEPTH'(1))) != '0, "occupied cells are not packed at the front")
  `DQ_ASSERT(a_full_flag_real, clk, rst_n, (pend_r && status_r == ST_FULL) |-> (cnt_r == CNT_W'(DEPTH)), "full status without a full queue")
  `DQ_ASSERT(a_result_after_pending, clk, rst_n, $rose(out_valid_r) |-> $past(pend_r), "result appeared without a pending command")

endmodule
